// ----- rtl/salc_pkg.sv -----
// Shared types and constants of the set-associative LRU cache hit model.
// Used by the top level; no dependencies of its own.
package salc_pkg;

  // beat and field widths
  localparam int unsigned ADDR_W      = 32;
  localparam int unsigned HIT_CNT_W   = 32;
  localparam int unsigned OUT_TDATA_W = 40;
  localparam int unsigned OUT_PAD_W   = OUT_TDATA_W - 2 - HIT_CNT_W;

  // configuration port
  localparam int unsigned CFG_IDX_W       = 1;
  localparam int unsigned CFG_DATA_W      = 3;
  localparam int unsigned WAYS_LOG2_W     = 3;
  localparam int unsigned MODE_W          = 2;
  localparam int unsigned WAYS_LOG2_RESET = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS_LOG2   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_POLICY_MODE = 1'b1;

  // allocation and prefetch policy
  typedef enum logic [MODE_W-1:0] {
    MODE_ALLOC       = 2'd0,
    MODE_NO_WR_ALLOC = 2'd1,
    MODE_PF_ALWAYS   = 2'd2,
    MODE_PF_MISS     = 2'd3
  } mode_e;

endpackage

// ----- rtl/salc_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module salc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/set_assoc_lru_cache_hit_model_unit.sv -----
// Tag-only set-associative LRU cache model with optional next-line prefetch.
// Depends on salc_pkg and salc_ram.
//
// The block takes one access at a time and answers each with one result beat
// (hit, prefetch_present, running hit count). A lookup scans its set through
// one shared tag/rank compare unit, one way per cycle out of the line memory,
// then walks the set again to write back the recency ranks; the set holds
// W = 2**ways_log2 ways (after clamping to MAX_WAYS and to the line count).
// A store miss that does not allocate skips the write-back walk. An access
// takes one lookup, or two when the policy prefetches the next line; the
// result is then handed over and the block goes back to idle, where the next
// access is taken, so no new access is taken before the last one is through.
// A new access is taken while the previous result still waits on the output;
// the handover of the new result then waits until the output register is free.
// After reset and after every ways_log2 write a clearing pass invalidates all
// CAPACITY_BYTES/LINE_BYTES lines (512 by default) of the line memory; no
// access is taken meanwhile, configuration writes are. The hit count survives
// a geometry change.
module set_assoc_lru_cache_hit_model_unit #(
  parameter int unsigned LINE_BYTES     = 32,
  parameter int unsigned CAPACITY_BYTES = 16384,
  parameter int unsigned MAX_WAYS       = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // access stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [salc_pkg::ADDR_W-1:0]         s_axis_tdata,  // [31:0] access_address
  input  logic [0:0]                          s_axis_tuser,  // [0] is_load
  // result stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [salc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,  // [0] hit, [1] prefetch_present,
                                                             // [33:2] hit_total, [39:34] zero
  // configuration writes
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [salc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [salc_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  // geometry
  localparam int unsigned TOTAL_LINES = CAPACITY_BYTES / LINE_BYTES;
  localparam int unsigned OFF_W       = $clog2(LINE_BYTES);
  localparam int unsigned LINES_W     = $clog2(TOTAL_LINES);
  localparam int unsigned LN_W        = salc_pkg::ADDR_W - OFF_W;
  localparam int unsigned MW_LOG2     = $clog2(MAX_WAYS + 1) - 1;
  localparam int unsigned WL_MAX      = (MW_LOG2 < LINES_W) ? MW_LOG2 : LINES_W;
  localparam int unsigned IDX_W       = (WL_MAX > 0) ? WL_MAX : 1;
  localparam int unsigned CNT_W       = WL_MAX + 1;
  localparam int unsigned RANK_W      = IDX_W;
  localparam int unsigned TAG_W       = LN_W - LINES_W + WL_MAX;
  localparam int unsigned ENT_W       = 1 + RANK_W + TAG_W;
  localparam int unsigned SH_W        = $clog2(LINES_W + 1);

  localparam logic [salc_pkg::WAYS_LOG2_W-1:0] WL_MAX_V =
    salc_pkg::WAYS_LOG2_W'(WL_MAX);
  localparam logic [salc_pkg::WAYS_LOG2_W-1:0] WL_RST_V =
    (WL_MAX < salc_pkg::WAYS_LOG2_RESET) ? WL_MAX_V :
    salc_pkg::WAYS_LOG2_W'(salc_pkg::WAYS_LOG2_RESET);

  // sequencer
  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_CLEAR  = 7'b0000010,
    ST_SETUP  = 7'b0000100,
    ST_SCAN   = 7'b0001000,
    ST_DECIDE = 7'b0010000,
    ST_UPDATE = 7'b0100000,
    ST_FINISH = 7'b1000000
  } state_e;

  state_e                           state_q, state_d;
  logic [salc_pkg::WAYS_LOG2_W-1:0] wl_q, wl_d;
  salc_pkg::mode_e                  mode_q, mode_d;
  logic [LINES_W-1:0]               clr_q, clr_d;
  logic [CNT_W-1:0]                 cnt_q, cnt_d;
  logic                             rd_vld_q, rd_vld_d;
  logic [IDX_W-1:0]                 pw_q, pw_d;
  logic                             pf_phase_q, pf_phase_d;
  logic [salc_pkg::HIT_CNT_W-1:0]   hit_cnt_q, hit_cnt_d;
  logic                             m_valid_q, m_valid_d;

  // lookup payload
  logic [LN_W-1:0]                  line_q, line_d;
  logic                             alloc_q, alloc_d;
  logic [LINES_W-1:0]               base_q, base_d;
  logic [TAG_W-1:0]                 tag_q, tag_d;
  logic                             hit_fnd_q, hit_fnd_d;
  logic [IDX_W-1:0]                 hit_way_q, hit_way_d;
  logic [RANK_W-1:0]                hit_rank_q, hit_rank_d;
  logic                             free_fnd_q, free_fnd_d;
  logic [IDX_W-1:0]                 free_way_q, free_way_d;
  logic [CNT_W-1:0]                 nval_q, nval_d;
  logic [IDX_W-1:0]                 vic_way_q, vic_way_d;
  logic [RANK_W-1:0]                vic_rank_q, vic_rank_d;
  logic [IDX_W-1:0]                 w_q, w_d;
  logic [CNT_W-1:0]                 old_q, old_d;
  logic                             hit_res_q, hit_res_d;
  logic                             pf_res_q, pf_res_d;
  logic [salc_pkg::OUT_TDATA_W-1:0] m_data_q, m_data_d;

  // memory port
  logic               ram_we;
  logic [LINES_W-1:0] ram_waddr;
  logic [ENT_W-1:0]   ram_wdata;
  logic [LINES_W-1:0] ram_raddr;
  logic [ENT_W-1:0]   ram_rdata;

  // misc combinational
  logic               cfg_we;
  logic [CNT_W-1:0]   ways;
  logic               last_rd;
  logic               rd_en;
  logic               e_v;
  logic [RANK_W-1:0]  e_rank;
  logic [TAG_W-1:0]   e_tag;
  logic               tag_eq;
  logic               rank_gt;
  logic               rank_below_old;
  logic               pf_need;
  logic               end_lookup;
  logic               out_load;
  logic [LINES_W-1:0] set_mask;
  logic [SH_W-1:0]    tag_sh;
  logic [LN_W-1:0]    tag_full;

  salc_ram #(
    .WIDTH (ENT_W),
    .DEPTH (TOTAL_LINES)
  ) u_lines (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign cfg_ready_o   = 1'b1;
  assign cfg_we        = cfg_valid_i & cfg_ready_o;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  assign ways    = CNT_W'(1) << wl_q;
  assign last_rd = (cnt_q == ways);

  // set index and tag of the current line
  assign set_mask = {LINES_W{1'b1}} >> wl_q;
  assign base_d   = (line_q[LINES_W-1:0] & set_mask) << wl_q;
  assign tag_sh   = SH_W'(LINES_W) - SH_W'(wl_q);
  assign tag_full = line_q >> tag_sh;
  assign tag_d    = tag_full[TAG_W-1:0];

  // shared compare unit on the entry coming out of the memory
  assign e_v            = ram_rdata[ENT_W-1];
  assign e_rank         = ram_rdata[TAG_W +: RANK_W];
  assign e_tag          = ram_rdata[TAG_W-1:0];
  assign tag_eq         = e_v && (e_tag == tag_q);
  assign rank_gt        = (e_rank > vic_rank_q);
  assign rank_below_old = (CNT_W'(e_rank) < old_q);

  assign pf_need = (mode_q == salc_pkg::MODE_PF_ALWAYS) ||
                   ((mode_q == salc_pkg::MODE_PF_MISS) && !hit_fnd_q);

  // one read per cycle while walking the set
  assign rd_en     = ((state_q == ST_SCAN) || (state_q == ST_UPDATE)) && !last_rd;
  assign ram_raddr = base_q | LINES_W'(cnt_q[IDX_W-1:0]);

  // write port: clearing pass or rank write-back
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = base_q | LINES_W'(pw_q);
    ram_wdata = ram_rdata;
    if (state_q == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_q;
      ram_wdata = '0;
    end else if ((state_q == ST_UPDATE) && rd_vld_q) begin
      if (pw_q == w_q) begin
        ram_we    = 1'b1;
        ram_wdata = {1'b1, RANK_W'(0), tag_q};
      end else if (e_v && rank_below_old) begin
        ram_we    = 1'b1;
        ram_wdata = {1'b1, e_rank + RANK_W'(1), e_tag};
      end
    end
  end

  // lookup ends after the decision (no write-back) or after the write-back walk
  always_comb begin
    end_lookup = 1'b0;
    if (state_q == ST_DECIDE) begin
      end_lookup = !(hit_fnd_q || alloc_q);
    end else if (state_q == ST_UPDATE) begin
      end_lookup = last_rd;
    end
  end

  assign out_load = (state_q == ST_FINISH) && (!m_valid_q || m_axis_tready);

  // sequencer and datapath next state
  always_comb begin
    state_d    = state_q;
    wl_d       = wl_q;
    mode_d     = mode_q;
    clr_d      = clr_q;
    cnt_d      = cnt_q;
    rd_vld_d   = rd_en;
    pw_d       = pw_q;
    pf_phase_d = pf_phase_q;
    hit_cnt_d  = hit_cnt_q;
    m_valid_d  = m_valid_q;
    line_d     = line_q;
    alloc_d    = alloc_q;
    hit_fnd_d  = hit_fnd_q;
    hit_way_d  = hit_way_q;
    hit_rank_d = hit_rank_q;
    free_fnd_d = free_fnd_q;
    free_way_d = free_way_q;
    nval_d     = nval_q;
    vic_way_d  = vic_way_q;
    vic_rank_d = vic_rank_q;
    w_d        = w_q;
    old_d      = old_q;
    hit_res_d  = hit_res_q;
    pf_res_d   = pf_res_q;
    m_data_d   = m_data_q;

    if (rd_en) begin
      cnt_d = cnt_q + CNT_W'(1);
      pw_d  = cnt_q[IDX_W-1:0];
    end

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          line_d     = s_axis_tdata[salc_pkg::ADDR_W-1:OFF_W];
          alloc_d    = !((mode_q == salc_pkg::MODE_NO_WR_ALLOC) && !s_axis_tuser[0]);
          pf_phase_d = 1'b0;
          pf_res_d   = 1'b0;
          state_d    = ST_SETUP;
        end
      end
      ST_CLEAR: begin
        clr_d = clr_q + LINES_W'(1);
        if (clr_q == {LINES_W{1'b1}}) begin
          state_d = ST_IDLE;
        end
      end
      ST_SETUP: begin
        cnt_d      = '0;
        hit_fnd_d  = 1'b0;
        free_fnd_d = 1'b0;
        nval_d     = '0;
        vic_way_d  = '0;
        vic_rank_d = '0;
        state_d    = ST_SCAN;
      end
      ST_SCAN: begin
        // accumulate the way that hits, the first free way and the oldest way
        if (rd_vld_q) begin
          if (e_v) begin
            nval_d = nval_q + CNT_W'(1);
          end
          if (tag_eq && !hit_fnd_q) begin
            hit_fnd_d  = 1'b1;
            hit_way_d  = pw_q;
            hit_rank_d = e_rank;
          end
          if (!e_v && !free_fnd_q) begin
            free_fnd_d = 1'b1;
            free_way_d = pw_q;
          end
          if ((pw_q == '0) || rank_gt) begin
            vic_way_d  = pw_q;
            vic_rank_d = e_rank;
          end
        end
        if (last_rd) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        cnt_d = '0;
        priority if (hit_fnd_q) begin
          w_d   = hit_way_q;
          old_d = CNT_W'(hit_rank_q);
        end else if (free_fnd_q) begin
          w_d   = free_way_q;
          old_d = nval_q;
        end else begin
          w_d   = vic_way_q;
          old_d = CNT_W'(vic_rank_q);
        end
        if (pf_phase_q) begin
          pf_res_d = hit_fnd_q;
        end else begin
          hit_res_d = hit_fnd_q;
          if (hit_fnd_q) begin
            hit_cnt_d = hit_cnt_q + salc_pkg::HIT_CNT_W'(1);
          end
        end
        if (hit_fnd_q || alloc_q) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        // write-back handled on the memory port
      end
      ST_FINISH: begin
        if (out_load) begin
          m_data_d = {salc_pkg::OUT_PAD_W'(0), hit_cnt_q, pf_res_q, hit_res_q};
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // lookup done: after the demand lookup start the next-line lookup if needed, else hand over the result
    if (end_lookup) begin
      if (!pf_phase_q && pf_need) begin
        pf_phase_d = 1'b1;
        line_d     = line_q + LN_W'(1);
        alloc_d    = 1'b1;
        state_d    = ST_SETUP;
      end else begin
        state_d = ST_FINISH;
      end
    end

    // output register
    if (out_load) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    // configuration writes; a geometry change restarts the clearing pass
    if (cfg_we) begin
      unique case (cfg_index_i)
        salc_pkg::CFG_WAYS_LOG2: begin
          wl_d    = (cfg_data_i > WL_MAX_V) ? WL_MAX_V : cfg_data_i;
          clr_d   = '0;
          state_d = ST_CLEAR;
        end
        salc_pkg::CFG_POLICY_MODE: begin
          mode_d = salc_pkg::mode_e'(cfg_data_i[salc_pkg::MODE_W-1:0]);
        end
        default: begin
        end
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      wl_q       <= WL_RST_V;
      mode_q     <= salc_pkg::MODE_ALLOC;
      clr_q      <= '0;
      cnt_q      <= '0;
      rd_vld_q   <= 1'b0;
      pw_q       <= '0;
      pf_phase_q <= 1'b0;
      hit_cnt_q  <= '0;
      m_valid_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      wl_q       <= wl_d;
      mode_q     <= mode_d;
      clr_q      <= clr_d;
      cnt_q      <= cnt_d;
      rd_vld_q   <= rd_vld_d;
      pw_q       <= pw_d;
      pf_phase_q <= pf_phase_d;
      hit_cnt_q  <= hit_cnt_d;
      m_valid_q  <= m_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    line_q     <= line_d;
    alloc_q    <= alloc_d;
    hit_fnd_q  <= hit_fnd_d;
    hit_way_q  <= hit_way_d;
    hit_rank_q <= hit_rank_d;
    free_fnd_q <= free_fnd_d;
    free_way_q <= free_way_d;
    nval_q     <= nval_d;
    vic_way_q  <= vic_way_d;
    vic_rank_q <= vic_rank_d;
    w_q        <= w_d;
    old_q      <= old_d;
    hit_res_q  <= hit_res_d;
    pf_res_q   <= pf_res_d;
    m_data_q   <= m_data_d;
    if (state_q == ST_SETUP) begin
      base_q <= base_d;
      tag_q  <= tag_d;
    end
  end

  // write-back never leaves the set being looked up
  a_upd_in_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_UPDATE) && ram_we) |-> ((ram_waddr >> wl_q) == (base_q >> wl_q)))
    else $error("rank write-back outside the current set");

  // the hit count only ever steps by one
  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hit_cnt_q != $past(hit_cnt_q)) |->
    (hit_cnt_q == $past(hit_cnt_q) + salc_pkg::HIT_CNT_W'(1)))
    else $error("hit count jumped");

  // a result beat appears only when a finished access hands it over
  a_out_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == ST_FINISH))
    else $error("result beat without a finished access");

  // replacement by rank only when every way of the set is valid
  a_victim_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_DECIDE) && !hit_fnd_q && !free_fnd_q) |-> (nval_q == ways))
    else $error("eviction while a free way exists");

  // a hit implies at least one valid way was counted
  a_hit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_DECIDE) && hit_fnd_q) |-> (nval_q != '0))
    else $error("hit without a valid way");

endmodule
